// ===== rtl/adjacency_table_engine_defines.svh =====
// Assertion macros for the checks in the engine top level.
`ifndef ADJACENCY_TABLE_ENGINE_DEFINES_SVH
`define ADJACENCY_TABLE_ENGINE_DEFINES_SVH

// Implication in the same cycle.
`define ATE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle.
`define ATE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ate_pkg.sv =====
package ate_pkg;

   localparam int IDW = 6;
   localparam int WW  = 32;

   localparam logic [3:0]  MAX_LIST      = 4'd8;
   localparam logic [31:0] WEIGHT_ABSENT = 32'hBF80_0000;

   typedef enum logic [3:0] {
      OP_CLEAR       = 4'd0,
      OP_ADD_NODE    = 4'd1,
      OP_REMOVE_NODE = 4'd2,
      OP_ADD_EDGE    = 4'd3,
      OP_ADD_BOTH    = 4'd4,
      OP_REMOVE_EDGE = 4'd5,
      OP_HAS_EDGE    = 4'd6,
      OP_GET_WEIGHT  = 4'd7,
      OP_NEIGHBORS   = 4'd8
   } opcode_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_PHASE2,
      ST_ROW_WAIT,
      ST_SCAN,
      ST_NB_ISSUE,
      ST_NB_SLOT,
      ST_NB_LIVE,
      ST_NB_FLUSH,
      ST_RM_ROW,
      ST_RM_ROWD,
      ST_RM_SLOT,
      ST_RM_SLOTD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             status;
      logic [IDW-1:0]   node_id;
      logic [WW-1:0]    weight_out;
      logic [3:0]       neighbor_index;
      logic             last;
   } result_type;

   typedef struct packed {
      logic           valid;
      result_type     data;
   } push_type;

   typedef struct packed {
      logic           live;
      logic [IDW-1:0] target;
      logic [WW-1:0]  weight;
   } slot_type;

endpackage

// ===== rtl/ate_ram.sv =====
module ate_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ate_seq.sv =====
module ate_seq #(
   parameter int NODES = 64,
   parameter int EDGES = 8,
   parameter int RW    = $clog2(NODES),
   parameter int CW    = $clog2(EDGES + 1),
   parameter int SAW   = $clog2(NODES * EDGES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [3:0]            req_opcode,
   input  logic [5:0]            req_source_node,
   input  logic [5:0]            req_target_node,
   input  logic [31:0]           req_weight_word,
   input  logic [3:0]            req_neighbor_limit,
   input  logic                  out_free,
   output ate_pkg::push_type     push,
   output logic                  row_wr_en,
   output logic [RW-1:0]         row_wr_addr,
   output logic [CW:0]           row_wr_data,
   output logic                  row_rd_en,
   output logic [RW-1:0]         row_rd_addr,
   input  logic [CW:0]           row_rd_data,
   output logic                  slot_wr_en,
   output logic [SAW-1:0]        slot_wr_addr,
   output ate_pkg::slot_type     slot_wr_data,
   output logic                  slot_rd_en,
   output logic [SAW-1:0]        slot_rd_addr,
   input  ate_pkg::slot_type     slot_rd_data
);

   localparam int TW   = $clog2(NODES + 1);
   localparam int CMPW = (TW > ate_pkg::IDW) ? TW : ate_pkg::IDW;

   ate_pkg::state_type  state_ff, state_in;
   ate_pkg::opcode_type op_ff, op_in;
   logic [5:0]          src_ff, src_in, dst_ff, dst_in;
   logic [31:0]         w_ff, w_in;
   logic [3:0]          lim_ff, lim_in;
   logic [TW-1:0]       total_ff, total_in;
   logic [RW-1:0]       cur_row_ff, cur_row_in;
   logic [5:0]          cur_tgt_ff, cur_tgt_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                rlive_ff, rlive_in;
   logic [CW-1:0]       j_ff, j_in;
   logic                pend_ff, pend_in;
   logic [CW-1:0]       pidx_ff, pidx_in;
   logic                phase_ff, phase_in;
   logic                any_ok_ff, any_ok_in;
   ate_pkg::result_type res_ff, res_in;
   ate_pkg::result_type held_ff, held_in;
   logic                held_v_ff, held_v_in;
   logic [3:0]          n_ff, n_in;
   logic [5:0]          nt_ff, nt_in;
   logic [31:0]         nwt_ff, nwt_in;
   logic [RW-1:0]       sweep_ff, sweep_in;
   logic                init_emit_ff, init_emit_in;
   logic [TW-1:0]       rm_row_ff, rm_row_in;

   logic                src_ok, dst_ok, node_full, tgt_ok;
   logic [SAW-1:0]      slot_base;
   logic                add_done, add_ok, add_all_ok;
   logic                scan_hit;
   logic                rd_live;
   logic [CW-1:0]       rd_cnt;

   function automatic ate_pkg::result_type mk(input logic st, input logic [5:0] id,
                                              input logic [31:0] w, input logic [3:0] idx,
                                              input logic lst);
      ate_pkg::result_type r;
      r.status         = st;
      r.node_id        = id;
      r.weight_out     = w;
      r.neighbor_index = idx;
      r.last           = lst;
      return r;
   endfunction

   assign src_ok    = CMPW'(src_ff) < CMPW'(total_ff);
   assign dst_ok    = CMPW'(dst_ff) < CMPW'(total_ff);
   assign node_full = total_ff == TW'(NODES);
   assign tgt_ok    = CMPW'(slot_rd_data.target) < CMPW'(NODES);
   assign slot_base = SAW'(cur_row_ff) * SAW'(EDGES);
   assign rd_live   = row_rd_data[CW];
   assign rd_cnt    = row_rd_data[CW-1:0];
   assign scan_hit  = pend_ff && slot_rd_data.live && (slot_rd_data.target == cur_tgt_ff);
   assign add_all_ok = any_ok_ff | add_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ate_pkg::ST_INIT;
         total_ff     <= '0;
         sweep_ff     <= '0;
         init_emit_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         sweep_ff     <= sweep_in;
         init_emit_ff <= init_emit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      w_ff       <= w_in;
      lim_ff     <= lim_in;
      cur_row_ff <= cur_row_in;
      cur_tgt_ff <= cur_tgt_in;
      cnt_ff     <= cnt_in;
      rlive_ff   <= rlive_in;
      j_ff       <= j_in;
      pend_ff    <= pend_in;
      pidx_ff    <= pidx_in;
      phase_ff   <= phase_in;
      any_ok_ff  <= any_ok_in;
      res_ff     <= res_in;
      held_ff    <= held_in;
      held_v_ff  <= held_v_in;
      n_ff       <= n_in;
      nt_ff      <= nt_in;
      nwt_ff     <= nwt_in;
      rm_row_ff  <= rm_row_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      w_in         = w_ff;
      lim_in       = lim_ff;
      total_in     = total_ff;
      cur_row_in   = cur_row_ff;
      cur_tgt_in   = cur_tgt_ff;
      cnt_in       = cnt_ff;
      rlive_in     = rlive_ff;
      j_in         = j_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      phase_in     = phase_ff;
      any_ok_in    = any_ok_ff;
      res_in       = res_ff;
      held_in      = held_ff;
      held_v_in    = held_v_ff;
      n_in         = n_ff;
      nt_in        = nt_ff;
      nwt_in       = nwt_ff;
      sweep_in     = sweep_ff;
      init_emit_in = init_emit_ff;
      rm_row_in    = rm_row_ff;
      req_ready    = 1'b0;
      push         = '0;
      row_wr_en    = 1'b0;
      row_wr_addr  = cur_row_ff;
      row_wr_data  = '0;
      row_rd_en    = 1'b0;
      row_rd_addr  = cur_row_ff;
      slot_wr_en   = 1'b0;
      slot_wr_addr = slot_base + SAW'(pidx_ff);
      slot_wr_data = slot_rd_data;
      slot_rd_en   = 1'b0;
      slot_rd_addr = slot_base + SAW'(j_ff);
      add_done     = 1'b0;
      add_ok       = 1'b0;

      unique case (state_ff)
         ate_pkg::ST_INIT: begin
            row_wr_en   = 1'b1;
            row_wr_addr = sweep_ff;
            if (sweep_ff == RW'(NODES - 1)) begin
               sweep_in = '0;
               if (init_emit_ff) begin
                  init_emit_in = 1'b0;
                  res_in       = mk(1'b0, '0, '0, '0, 1'b1);
                  state_in     = ate_pkg::ST_EMIT;
               end else begin
                  state_in = ate_pkg::ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + RW'(1);
            end
         end

         ate_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = ate_pkg::opcode_type'(req_opcode);
               src_in   = req_source_node;
               dst_in   = req_target_node;
               w_in     = req_weight_word;
               lim_in   = (req_neighbor_limit > ate_pkg::MAX_LIST) ? ate_pkg::MAX_LIST
                                                                  : req_neighbor_limit;
               state_in = ate_pkg::ST_DISPATCH;
            end
         end

         ate_pkg::ST_DISPATCH: begin
            cur_row_in = RW'(src_ff);
            cur_tgt_in = dst_ff;
            phase_in   = 1'b0;
            any_ok_in  = 1'b0;
            res_in     = mk(1'b1, '0, '0, '0, 1'b1);
            state_in   = ate_pkg::ST_EMIT;
            unique case (op_ff)
               ate_pkg::OP_CLEAR: begin
                  total_in     = '0;
                  sweep_in     = '0;
                  init_emit_in = 1'b1;
                  state_in     = ate_pkg::ST_INIT;
               end
               ate_pkg::OP_ADD_NODE: begin
                  if (!node_full) begin
                     row_rd_en   = 1'b1;
                     row_rd_addr = RW'(total_ff);
                     state_in    = ate_pkg::ST_ROW_WAIT;
                  end
               end
               ate_pkg::OP_REMOVE_NODE: begin
                  if (src_ok) begin
                     row_wr_en   = 1'b1;
                     row_wr_addr = RW'(src_ff);
                     rm_row_in   = '0;
                     state_in    = ate_pkg::ST_RM_ROW;
                  end
               end
               ate_pkg::OP_ADD_EDGE, ate_pkg::OP_ADD_BOTH: begin
                  if (src_ok && dst_ok) begin
                     row_rd_en   = 1'b1;
                     row_rd_addr = RW'(src_ff);
                     state_in    = ate_pkg::ST_ROW_WAIT;
                  end
               end
               ate_pkg::OP_REMOVE_EDGE, ate_pkg::OP_HAS_EDGE, ate_pkg::OP_GET_WEIGHT: begin
                  if (src_ok) begin
                     row_rd_en   = 1'b1;
                     row_rd_addr = RW'(src_ff);
                     state_in    = ate_pkg::ST_ROW_WAIT;
                  end else if (op_ff == ate_pkg::OP_GET_WEIGHT) begin
                     res_in = mk(1'b1, '0, ate_pkg::WEIGHT_ABSENT, '0, 1'b1);
                  end
               end
               ate_pkg::OP_NEIGHBORS: begin
                  if (src_ok && (lim_ff != '0)) begin
                     row_rd_en   = 1'b1;
                     row_rd_addr = RW'(src_ff);
                     state_in    = ate_pkg::ST_ROW_WAIT;
                  end
               end
               default: begin
                  state_in = ate_pkg::ST_EMIT;
               end
            endcase
         end

         ate_pkg::ST_PHASE2: begin
            // row written last cycle may be this one: read it only now
            row_rd_en = 1'b1;
            state_in  = ate_pkg::ST_ROW_WAIT;
         end

         ate_pkg::ST_ROW_WAIT: begin
            cnt_in    = rd_cnt;
            rlive_in  = rd_live;
            j_in      = '0;
            pend_in   = 1'b0;
            n_in      = '0;
            held_v_in = 1'b0;
            unique case (op_ff)
               ate_pkg::OP_ADD_NODE: begin
                  row_wr_en   = 1'b1;
                  row_wr_addr = RW'(total_ff);
                  row_wr_data = {1'b1, rd_cnt};
                  res_in      = mk(1'b0, ate_pkg::IDW'(total_ff), '0, '0, 1'b1);
                  total_in    = total_ff + TW'(1);
                  state_in    = ate_pkg::ST_EMIT;
               end
               ate_pkg::OP_ADD_EDGE, ate_pkg::OP_ADD_BOTH: begin
                  if (rd_cnt >= CW'(EDGES)) begin
                     add_done = 1'b1;
                  end else begin
                     state_in = ate_pkg::ST_SCAN;
                  end
               end
               ate_pkg::OP_NEIGHBORS: begin
                  state_in = ate_pkg::ST_NB_ISSUE;
               end
               default: begin
                  state_in = ate_pkg::ST_SCAN;
               end
            endcase
         end

         ate_pkg::ST_SCAN: begin
            // one slot read issued per cycle, the previous one checked
            if (scan_hit) begin
               pend_in  = 1'b0;
               state_in = ate_pkg::ST_EMIT;
               unique case (op_ff)
                  ate_pkg::OP_ADD_EDGE, ate_pkg::OP_ADD_BOTH: begin
                     add_done = 1'b1;
                  end
                  ate_pkg::OP_REMOVE_EDGE: begin
                     slot_wr_en        = 1'b1;
                     slot_wr_data.live = 1'b0;
                     res_in            = mk(1'b0, '0, '0, '0, 1'b1);
                  end
                  ate_pkg::OP_GET_WEIGHT: begin
                     res_in = mk(1'b0, '0, slot_rd_data.weight, '0, 1'b1);
                  end
                  default: begin
                     res_in = mk(1'b0, '0, '0, '0, 1'b1);
                  end
               endcase
            end else if (j_ff < cnt_ff) begin
               slot_rd_en = 1'b1;
               pend_in    = 1'b1;
               pidx_in    = j_ff;
               j_in       = j_ff + CW'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = ate_pkg::ST_EMIT;
               unique case (op_ff)
                  ate_pkg::OP_ADD_EDGE, ate_pkg::OP_ADD_BOTH: begin
                     slot_wr_en          = 1'b1;
                     slot_wr_addr        = slot_base + SAW'(cnt_ff);
                     slot_wr_data.live   = 1'b1;
                     slot_wr_data.target = cur_tgt_ff;
                     slot_wr_data.weight = w_ff;
                     row_wr_en           = 1'b1;
                     row_wr_data         = {rlive_ff, cnt_ff + CW'(1)};
                     add_done            = 1'b1;
                     add_ok              = 1'b1;
                  end
                  ate_pkg::OP_GET_WEIGHT: begin
                     res_in = mk(1'b1, '0, ate_pkg::WEIGHT_ABSENT, '0, 1'b1);
                  end
                  default: begin
                     res_in = mk(1'b1, '0, '0, '0, 1'b1);
                  end
               endcase
            end
         end

         ate_pkg::ST_NB_ISSUE: begin
            if ((j_ff < cnt_ff) && (n_ff < lim_ff)) begin
               slot_rd_en = 1'b1;
               j_in       = j_ff + CW'(1);
               state_in   = ate_pkg::ST_NB_SLOT;
            end else begin
               state_in = ate_pkg::ST_NB_FLUSH;
            end
         end

         ate_pkg::ST_NB_SLOT: begin
            state_in = ate_pkg::ST_NB_ISSUE;
            if (slot_rd_data.live && tgt_ok) begin
               nt_in       = slot_rd_data.target;
               nwt_in      = slot_rd_data.weight;
               row_rd_en   = 1'b1;
               row_rd_addr = RW'(slot_rd_data.target);
               state_in    = ate_pkg::ST_NB_LIVE;
            end
         end

         ate_pkg::ST_NB_LIVE: begin
            if (!rd_live) begin
               state_in = ate_pkg::ST_NB_ISSUE;
            end else if (!held_v_ff || out_free) begin
               // release the held neighbour: another one follows it
               push.valid = held_v_ff;
               push.data  = held_ff;
               held_in    = mk(1'b0, nt_ff, nwt_ff, n_ff + 4'd1, 1'b0);
               held_v_in  = 1'b1;
               n_in       = n_ff + 4'd1;
               state_in   = ate_pkg::ST_NB_ISSUE;
            end
         end

         ate_pkg::ST_NB_FLUSH: begin
            if (held_v_ff) begin
               res_in      = held_ff;
               res_in.last = 1'b1;
            end else begin
               res_in = mk(1'b1, '0, '0, '0, 1'b1);
            end
            held_v_in = 1'b0;
            state_in  = ate_pkg::ST_EMIT;
         end

         ate_pkg::ST_RM_ROW: begin
            if (rm_row_ff < total_ff) begin
               row_rd_en   = 1'b1;
               row_rd_addr = RW'(rm_row_ff);
               state_in    = ate_pkg::ST_RM_ROWD;
            end else begin
               res_in   = mk(1'b0, '0, '0, '0, 1'b1);
               state_in = ate_pkg::ST_EMIT;
            end
         end

         ate_pkg::ST_RM_ROWD: begin
            cnt_in     = rd_cnt;
            j_in       = '0;
            cur_row_in = RW'(rm_row_ff);
            state_in   = ate_pkg::ST_RM_SLOT;
         end

         ate_pkg::ST_RM_SLOT: begin
            if (j_ff < cnt_ff) begin
               slot_rd_en = 1'b1;
               pidx_in    = j_ff;
               j_in       = j_ff + CW'(1);
               state_in   = ate_pkg::ST_RM_SLOTD;
            end else begin
               rm_row_in = rm_row_ff + TW'(1);
               state_in  = ate_pkg::ST_RM_ROW;
            end
         end

         ate_pkg::ST_RM_SLOTD: begin
            if (slot_rd_data.target == src_ff) begin
               slot_wr_en        = 1'b1;
               slot_wr_data.live = 1'b0;
            end
            state_in = ate_pkg::ST_RM_SLOT;
         end

         ate_pkg::ST_EMIT: begin
            if (out_free) begin
               push.valid = 1'b1;
               push.data  = res_ff;
               state_in   = ate_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ate_pkg::ST_IDLE;
         end
      endcase

      // close one direction of an edge add
      if (add_done) begin
         if ((op_ff == ate_pkg::OP_ADD_BOTH) && !phase_ff) begin
            phase_in   = 1'b1;
            any_ok_in  = add_all_ok;
            cur_row_in = RW'(dst_ff);
            cur_tgt_in = src_ff;
            state_in   = ate_pkg::ST_PHASE2;
         end else begin
            res_in   = mk(!add_all_ok, '0, '0, '0, 1'b1);
            state_in = ate_pkg::ST_EMIT;
         end
      end
   end

endmodule

// ===== rtl/adjacency_table_engine.sv =====
// Directed graph store with NODES nodes of EDGES edge slots each, taking one
// transaction at a time and answering with one result (up to eight for a
// neighbour listing, the final one flagged by rsp_last). Node state (live bit
// and used slot count) sits in a row memory and the edge slots in a slot
// memory, both single write / single read with registered read data.
// Has edge, get weight and remove edge scan the used slots of the row
// concerned, the slot memory read port scanning one slot per cycle; add
// edge the same, add both ways for both rows; list neighbours needs for
// each slot a slot read then a row read for the target's live bit.
// Remove node walks every row handed out and the used slots of each. After
// reset and after every clear the row memory is swept one entry per cycle,
// while no transaction is accepted. A result waiting on rsp does not stop
// the next transaction from being taken.
`include "adjacency_table_engine_defines.svh"

module adjacency_table_engine #(
   parameter int NODES = 64,
   parameter int EDGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [5:0]  req_source_node,
   input  logic [5:0]  req_target_node,
   input  logic [31:0] req_weight_word,
   input  logic [3:0]  req_neighbor_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [5:0]  rsp_node_id,
   output logic [31:0] rsp_weight_out,
   output logic [3:0]  rsp_neighbor_index,
   output logic        rsp_last
);

   localparam int RW  = $clog2(NODES);
   localparam int CW  = $clog2(EDGES + 1);
   localparam int SAW = $clog2(NODES * EDGES);
   localparam int SLW = $bits(ate_pkg::slot_type);

   ate_pkg::push_type   push;
   ate_pkg::result_type rsp_data_ff;
   logic                rsp_valid_ff;
   logic                out_free;

   logic                row_wr_en, row_rd_en;
   logic [RW-1:0]       row_wr_addr, row_rd_addr;
   logic [CW:0]         row_wr_data, row_rd_data;
   logic                slot_wr_en, slot_rd_en;
   logic [SAW-1:0]      slot_wr_addr, slot_rd_addr;
   ate_pkg::slot_type   slot_wr_data, slot_rd_data;
   logic [SLW-1:0]      slot_rd_raw;

   // sequencer: decodes the transaction and drives both memories
   ate_seq #(
      .NODES (NODES),
      .EDGES (EDGES),
      .RW    (RW),
      .CW    (CW),
      .SAW   (SAW)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_source_node    (req_source_node),
      .req_target_node    (req_target_node),
      .req_weight_word    (req_weight_word),
      .req_neighbor_limit (req_neighbor_limit),
      .out_free           (out_free),
      .push               (push),
      .row_wr_en          (row_wr_en),
      .row_wr_addr        (row_wr_addr),
      .row_wr_data        (row_wr_data),
      .row_rd_en          (row_rd_en),
      .row_rd_addr        (row_rd_addr),
      .row_rd_data        (row_rd_data),
      .slot_wr_en         (slot_wr_en),
      .slot_wr_addr       (slot_wr_addr),
      .slot_wr_data       (slot_wr_data),
      .slot_rd_en         (slot_rd_en),
      .slot_rd_addr       (slot_rd_addr),
      .slot_rd_data       (slot_rd_data)
   );

   // per-node live bit and used slot count
   ate_ram #(
      .DEPTH (NODES),
      .WIDTH (CW + 1),
      .AW    (RW)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   // edge slots, row-major: node * EDGES + slot
   ate_ram #(
      .DEPTH (NODES * EDGES),
      .WIDTH (SLW),
      .AW    (SAW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_raw)
   );

   assign slot_rd_data = ate_pkg::slot_type'(slot_rd_raw);

   // output register: load a result when free, drop it once taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_data_ff <= push.data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_node_id        = rsp_data_ff.node_id;
   assign rsp_weight_out     = rsp_data_ff.weight_out;
   assign rsp_neighbor_index = rsp_data_ff.neighbor_index;
   assign rsp_last           = rsp_data_ff.last;

   // one transaction in flight at a time
   `ATE_ASSERT_NEXT(a_single_txn, clock, reset, req_valid && req_ready, !req_ready, "accepted a transaction while busy")
   // only neighbour listings give non-final results, and those are hits
   `ATE_ASSERT_SAME(a_mid_ok, clock, reset, rsp_valid && !rsp_last, !rsp_status, "non-final result with failure status")
   // listing count bounded
   `ATE_ASSERT_SAME(a_index_max, clock, reset, rsp_valid, rsp_neighbor_index <= ate_pkg::MAX_LIST, "neighbour index beyond limit")

endmodule
